// ===== design/mpsq_pkg.sv =====
// Package for the multi-pop shifting command queue.
// Holds queue sizes, field widths and the word types; no dependencies.
package mpsq_pkg;

    localparam int DEPTH       = 8;
    localparam int ENTRY_WIDTH = 64;
    localparam int FIELD_W     = 64;
    localparam int CNT_W       = $clog2(DEPTH + 1);

    // most entries one step may remove
    localparam logic [1:0] POP_LIMIT = 2'd2;

    typedef logic [ENTRY_WIDTH-1:0] t_entry;
    typedef logic [CNT_W-1:0]       t_count;

    typedef struct packed {
        logic               push_valid;
        logic [FIELD_W-1:0] push_data;
        logic [1:0]         pop_request;
    } t_cmd;

    typedef struct packed {
        logic               push_accepted;
        logic               front_valid;
        logic [FIELD_W-1:0] front_data;
        logic               second_valid;
        logic [FIELD_W-1:0] second_data;
    } t_result;

    typedef struct packed {
        t_count count;
        logic   full;
    } t_status;

endpackage

// ===== design/mpsq_queue.sv =====
// Queue storage and one-step update: pop, collapse, push.
// Depends on mpsq_pkg for sizes and the command/result words.
module mpsq_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  mpsq_pkg::t_cmd   i_cmd,
    output mpsq_pkg::t_result o_result,
    output mpsq_pkg::t_status o_status
);

    localparam int DP = mpsq_pkg::DEPTH;
    localparam int CW = mpsq_pkg::CNT_W;
    localparam int EW = mpsq_pkg::ENTRY_WIDTH;
    localparam int FW = mpsq_pkg::FIELD_W;
    localparam logic [CW-1:0] FULL = CW'(DP);

    mpsq_pkg::t_entry r_slots [DP];
    mpsq_pkg::t_entry n_slots [DP];
    mpsq_pkg::t_count r_count;
    mpsq_pkg::t_count n_count;

    logic [1:0]       pop_lim;
    mpsq_pkg::t_count take;
    mpsq_pkg::t_count keep;
    logic             ready;
    logic             accept;
    mpsq_pkg::t_entry word;
    mpsq_pkg::t_entry src;

    always_comb begin
        pop_lim = (i_cmd.pop_request > mpsq_pkg::POP_LIMIT) ? mpsq_pkg::POP_LIMIT
                                                             : i_cmd.pop_request;
        take    = (CW'(pop_lim) > r_count) ? r_count : CW'(pop_lim);
        keep    = r_count - take;
        ready   = (r_count < FULL);
        accept  = i_cmd.push_valid && ready;
        word    = i_cmd.push_data[EW-1:0];
        src     = '0;
        for (int i = 0; i < DP; i++) begin
            // collapse toward the front by the pop amount
            if (take == CW'(0)) begin
                src = r_slots[i];
            end else if (take == CW'(1)) begin
                src = (i + 1 < DP) ? r_slots[(i + 1) % DP] : '0;
            end else begin
                src = (i + 2 < DP) ? r_slots[(i + 2) % DP] : '0;
            end
            n_slots[i] = (CW'(i) < keep) ? src : '0;
            if (accept && (CW'(i) == keep)) begin
                n_slots[i] = word;
            end
        end
        n_count = keep + CW'(accept);

        o_result.push_accepted = accept;
        o_result.front_valid   = (n_count >= CW'(1));
        o_result.front_data    = o_result.front_valid ? FW'(n_slots[0]) : '0;
        o_result.second_valid  = (n_count >= CW'(2));
        o_result.second_data   = o_result.second_valid ? FW'(n_slots[1]) : '0;

        o_status.count = r_count;
        o_status.full  = !ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int i = 0; i < DP; i++) begin
                r_slots[i] <= '0;
            end
        end else if (i_step) begin
            r_count <= n_count;
            for (int i = 0; i < DP; i++) begin
                r_slots[i] <= n_slots[i];
            end
        end
    end

endmodule

// ===== design/multi_pop_shifting_command_queue.sv =====
// Multi-pop shifting command queue: input register, queue step, result register.
// Throughput is 1 word/cycle while the output is not stalled.
// The queue state advances as a word moves from the input to the result register.
// Reset (synchronous, active low) empties the queue and clears all slots to zero.
// Depends on mpsq_pkg and mpsq_queue.
module multi_pop_shifting_command_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_push_valid,
    input  logic [63:0] i_push_data,
    input  logic [1:0]  i_pop_request,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_push_accepted,
    output logic        o_front_valid,
    output logic [63:0] o_front_data,
    output logic        o_second_valid,
    output logic [63:0] o_second_data
);

    logic              r_in_vld;
    mpsq_pkg::t_cmd    r_cmd;
    logic              r_out_vld;
    mpsq_pkg::t_result r_result;

    mpsq_pkg::t_result w_result;
    mpsq_pkg::t_status w_status;
    logic              move;
    logic              load;

    // advance a word when the result register is free or being drained
    assign move       = r_in_vld && (!r_out_vld || !i_out_stall);
    assign load       = !r_in_vld || move;
    assign o_in_stall = !load;

    mpsq_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (move),
        .i_cmd    (r_cmd),
        .o_result (w_result),
        .o_status (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (load) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_in_valid) begin
            r_cmd.push_valid  <= i_push_valid;
            r_cmd.push_data   <= i_push_data;
            r_cmd.pop_request <= i_pop_request;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (move) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_push_accepted = r_result.push_accepted;
    assign o_front_valid   = r_result.front_valid;
    assign o_front_data    = r_result.front_data;
    assign o_second_valid  = r_result.second_valid;
    assign o_second_data   = r_result.second_data;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.count <= mpsq_pkg::CNT_W'(mpsq_pkg::DEPTH))
        else $error("queue count above depth");

    a_full_refuses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move && w_status.full |-> !w_result.push_accepted)
        else $error("push accepted into full queue");

    a_empty_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_result.front_valid |->
            (r_result.front_data == '0) && !r_result.second_valid)
        else $error("empty front shows data or second entry");

    a_second_implies_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_result.second_valid |-> r_result.front_valid)
        else $error("second entry valid without front entry");
`endif

endmodule
